/* hw/rtl/rlpd_pkg.sv */
package rlpd_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_DEPTH = 16;
  localparam int DEF_LEN_BITS  = 32;

  // item_kind codes
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_LAST  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // error_code codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_NONCANON  = 3'd1;
  localparam logic [2:0] ERR_LEAD_ZERO = 3'd2;
  localparam logic [2:0] ERR_SHORT_LF  = 3'd3;
  localparam logic [2:0] ERR_OVERRUN   = 3'd4;
  localparam logic [2:0] ERR_TOO_WIDE  = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd7;

  // prefix byte boundaries
  localparam logic [7:0] B_SINGLE_MAX = 8'h7f;
  localparam logic [7:0] B_STR_EMPTY  = 8'h80;
  localparam logic [7:0] B_STR_ONE    = 8'h81;
  localparam logic [7:0] B_STR_SHORT  = 8'hb7;
  localparam logic [7:0] B_STR_LONG   = 8'hbf;
  localparam logic [7:0] B_LIST_EMPTY = 8'hc0;
  localparam logic [7:0] B_LIST_SHORT = 8'hf7;
  localparam int         LONG_MIN     = 56;

  // list stack commands
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctl_t;

  // list stack status
  typedef struct packed {
    logic empty;     // no open list
    logic full;      // MAX_DEPTH lists open
    logic last_run;  // top run of equal ends is the only one
  } stk_stat_t;

endpackage

/* hw/rtl/rlpd_stack.sv */
module rlpd_stack #(
  parameter int MAX_DEPTH = rlpd_pkg::DEF_MAX_DEPTH,
  parameter int LEN_BITS  = rlpd_pkg::DEF_LEN_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rlpd_pkg::stk_ctl_t   ctl,
  input  logic [LEN_BITS-1:0]  push_end,
  output rlpd_pkg::stk_stat_t  stat,
  output logic [LEN_BITS-1:0]  top_end
);

  // Nested ends never increase toward the top, so lists sharing an end sit
  // together; each entry holds one distinct end and how many lists share it.
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [LEN_BITS-1:0] end_mem [MAX_DEPTH];
  logic [DW-1:0]       cnt_mem [MAX_DEPTH];
  logic [DW-1:0]       dptr;   // distinct entries
  logic [DW-1:0]       level;  // open lists
  logic [DW-1:0]       dptr_dec;
  logic [IW-1:0]       top_idx;
  logic [IW-1:0]       wr_idx;
  logic                merge;

  assign dptr_dec = dptr - DW'(1);
  assign top_idx  = dptr_dec[IW-1:0];
  assign wr_idx   = dptr[IW-1:0];
  assign top_end  = end_mem[top_idx];
  assign merge    = (dptr != '0) && (end_mem[top_idx] == push_end);

  assign stat.empty    = (level == '0);
  assign stat.full     = (level == DW'(MAX_DEPTH));
  assign stat.last_run = (dptr == DW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      dptr  <= '0;
      level <= '0;
    end else if (ctl.clear) begin
      dptr  <= '0;
      level <= '0;
    end else if (ctl.push) begin
      level <= level + DW'(1);
      if (!merge) begin
        dptr <= dptr + DW'(1);
      end
    end else if (ctl.pop) begin
      level <= level - cnt_mem[top_idx];
      dptr  <= dptr_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      if (merge) begin
        cnt_mem[top_idx] <= cnt_mem[top_idx] + DW'(1);
      end else begin
        end_mem[wr_idx] <= push_end;
        cnt_mem[wr_idx] <= DW'(1);
      end
    end
  end

endmodule

/* hw/rtl/rlpd_parse.sv */
module rlpd_parse #(
  parameter int LEN_BITS = rlpd_pkg::DEF_LEN_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  rlpd_pkg::stk_stat_t  stat,
  input  logic [LEN_BITS-1:0]  top_end,
  output rlpd_pkg::stk_ctl_t   ctl,
  output logic [LEN_BITS-1:0]  push_end,
  output logic [7:0]           res_byte,
  output logic [1:0]           res_kind,
  output logic [2:0]           res_err
);

  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]          phase, phase_next;
  logic [3:0]          len_left, len_left_next, len_left_dec;
  logic [LEN_BITS-1:0] accum, accum_next, acc_shift;
  logic                pend_list, pend_list_next;
  logic                one_chk, one_chk_next;
  logic [LEN_BITS-1:0] str_left, str_left_next, str_left_dec;
  logic [LEN_BITS-1:0] pos;
  logic [2:0]          held_err;

  logic [LEN_BITS-1:0] nxt;
  logic [7:0]          n_small;
  logic [LEN_BITS-1:0] n_sel;
  logic [LEN_BITS:0]   end_sum;
  logic [2:0]          end_err;
  logic [2:0]          err_take, err_final;
  logic                done, pop_hit, push_req, pop_req, take_ok, lvl_zero_next;
  logic [1:0]          kind;
  logic [7:0]          obyte;

  assign nxt       = pos + LEN_BITS'(1);
  assign acc_shift = {accum[LEN_BITS-9:0], in_byte};

  // length handed to the end-position adder
  always_comb begin
    if (in_byte <= rlpd_pkg::B_STR_SHORT) begin
      n_small = in_byte - rlpd_pkg::B_STR_EMPTY;
    end else if (in_byte <= rlpd_pkg::B_STR_LONG) begin
      n_small = in_byte - rlpd_pkg::B_STR_SHORT;
    end else if (in_byte <= rlpd_pkg::B_LIST_SHORT) begin
      n_small = in_byte - rlpd_pkg::B_LIST_EMPTY;
    end else begin
      n_small = in_byte - rlpd_pkg::B_LIST_SHORT;
    end
    if (phase == PH_LENGTH) begin
      n_sel = acc_shift;
    end else begin
      n_sel = {{(LEN_BITS-8){1'b0}}, n_small};
    end
  end

  // item end position with range and enclosing-list checks
  assign end_sum  = {1'b0, nxt} + {1'b0, n_sel};
  assign push_end = end_sum[LEN_BITS-1:0];
  always_comb begin
    if (end_sum[LEN_BITS]) begin
      end_err = rlpd_pkg::ERR_TOO_WIDE;
    end else if (!stat.empty && (end_sum[LEN_BITS-1:0] > top_end)) begin
      end_err = rlpd_pkg::ERR_OVERRUN;
    end else begin
      end_err = rlpd_pkg::ERR_OK;
    end
  end

  assign len_left_dec = (len_left != 4'd0) ? len_left - 4'd1 : 4'd0;
  assign str_left_dec = (str_left != '0) ? str_left - LEN_BITS'(1) : '0;
  assign pop_hit      = !stat.empty && (top_end == nxt);

  always_comb begin
    phase_next     = phase;
    len_left_next  = len_left;
    accum_next     = accum;
    pend_list_next = pend_list;
    one_chk_next   = one_chk;
    str_left_next  = str_left;
    err_take       = rlpd_pkg::ERR_OK;
    kind           = rlpd_pkg::KIND_NONE;
    obyte          = 8'd0;
    done           = 1'b0;
    push_req       = 1'b0;
    unique case (phase)
      PH_LENGTH: begin
        if (accum == '0 && in_byte == 8'd0) begin
          err_take = rlpd_pkg::ERR_LEAD_ZERO;
        end else if (accum[LEN_BITS-1 -: 8] != 8'd0) begin
          err_take = rlpd_pkg::ERR_TOO_WIDE;
        end else begin
          accum_next    = acc_shift;
          len_left_next = len_left_dec;
          if (len_left_dec == 4'd0) begin
            if (acc_shift < LEN_BITS'(rlpd_pkg::LONG_MIN)) begin
              err_take = rlpd_pkg::ERR_SHORT_LF;
            end else if (end_err != rlpd_pkg::ERR_OK) begin
              err_take = end_err;
            end else if (pend_list) begin
              if (stat.full) begin
                err_take = rlpd_pkg::ERR_TOO_DEEP;
              end else begin
                push_req   = 1'b1;
                phase_next = PH_PREFIX;
              end
            end else begin
              str_left_next = acc_shift;
              one_chk_next  = 1'b0;
              phase_next    = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (one_chk && in_byte <= rlpd_pkg::B_SINGLE_MAX) begin
          err_take = rlpd_pkg::ERR_NONCANON;
        end else begin
          one_chk_next  = 1'b0;
          obyte         = in_byte;
          str_left_next = str_left_dec;
          if (str_left_dec == '0) begin
            kind       = rlpd_pkg::KIND_LAST;
            phase_next = PH_PREFIX;
            done       = 1'b1;
          end else begin
            kind = rlpd_pkg::KIND_BYTE;
          end
        end
      end
      default: begin
        // prefix; the unused fourth code behaves the same
        phase_next = PH_PREFIX;
        if (in_byte <= rlpd_pkg::B_SINGLE_MAX) begin
          obyte = in_byte;
          kind  = rlpd_pkg::KIND_LAST;
          done  = 1'b1;
        end else if (in_byte == rlpd_pkg::B_STR_EMPTY) begin
          kind = rlpd_pkg::KIND_EMPTY;
          done = 1'b1;
        end else if (in_byte <= rlpd_pkg::B_STR_SHORT) begin
          if (end_err != rlpd_pkg::ERR_OK) begin
            err_take = end_err;
          end else begin
            str_left_next = n_sel;
            one_chk_next  = (in_byte == rlpd_pkg::B_STR_ONE);
            phase_next    = PH_PAYLOAD;
          end
        end else if (in_byte <= rlpd_pkg::B_STR_LONG || in_byte > rlpd_pkg::B_LIST_SHORT) begin
          if (end_err != rlpd_pkg::ERR_OK) begin
            err_take = end_err;
          end else begin
            len_left_next  = n_small[3:0];
            accum_next     = '0;
            pend_list_next = (in_byte > rlpd_pkg::B_LIST_SHORT);
            phase_next     = PH_LENGTH;
          end
        end else if (in_byte == rlpd_pkg::B_LIST_EMPTY) begin
          done = 1'b1;
        end else begin
          if (end_err != rlpd_pkg::ERR_OK) begin
            err_take = end_err;
          end else if (stat.full) begin
            err_take = rlpd_pkg::ERR_TOO_DEEP;
          end else begin
            push_req = 1'b1;
          end
        end
      end
    endcase
  end

  assign pop_req       = done && pop_hit;
  assign take_ok       = (held_err == rlpd_pkg::ERR_OK) && (err_take == rlpd_pkg::ERR_OK);
  assign lvl_zero_next = (stat.empty && !push_req) || (pop_req && stat.last_run);

  always_comb begin
    if (held_err != rlpd_pkg::ERR_OK) begin
      err_final = held_err;
    end else if (err_take != rlpd_pkg::ERR_OK) begin
      err_final = err_take;
    end else if (in_last && (phase_next != PH_PREFIX || !lvl_zero_next)) begin
      err_final = rlpd_pkg::ERR_TRUNC;
    end else begin
      err_final = rlpd_pkg::ERR_OK;
    end
  end

  assign res_err  = err_final;
  assign res_kind = (err_final != rlpd_pkg::ERR_OK) ? rlpd_pkg::KIND_NONE : kind;
  assign res_byte = (err_final != rlpd_pkg::ERR_OK) ? 8'd0 : obyte;

  assign ctl.push  = adv && take_ok && push_req && !in_last;
  assign ctl.pop   = adv && take_ok && pop_req && !in_last;
  assign ctl.clear = adv && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PREFIX;
      len_left  <= 4'd0;
      accum     <= '0;
      pend_list <= 1'b0;
      one_chk   <= 1'b0;
      str_left  <= '0;
      pos       <= '0;
      held_err  <= rlpd_pkg::ERR_OK;
    end else if (adv) begin
      if (in_last) begin
        phase     <= PH_PREFIX;
        len_left  <= 4'd0;
        accum     <= '0;
        pend_list <= 1'b0;
        one_chk   <= 1'b0;
        str_left  <= '0;
        pos       <= '0;
        held_err  <= rlpd_pkg::ERR_OK;
      end else begin
        phase     <= phase_next;
        len_left  <= len_left_next;
        accum     <= accum_next;
        pend_list <= pend_list_next;
        one_chk   <= one_chk_next;
        str_left  <= str_left_next;
        pos       <= nxt;
        held_err  <= err_final;
      end
    end
  end

endmodule

/* hw/rtl/rlp_stream_decoder_core.sv */
// Streaming recursive-length-prefix decoder, one encoded byte per beat.
// Input channel: in_valid / in_stall with in_byte and in_last; in_last
//   marks the final byte of a stream.
// Output channel: out_valid / out_stall; exactly one result beat for every
//   input beat, in order: out_byte, item_kind, error_code, stream_end.
// Strings come out byte by byte with the last byte marked; lists are
//   flattened and only tracked on an internal stack of open-list ends.
// Path: an accepted beat sits in the input register and is decoded into the
//   output register once that register is free or draining; its result then
//   waits on the output port until it is taken. Throughput: one byte per
//   cycle while the output is not stalled, set by the single decode step
//   between the input and the output register.
// The first error sticks: later beats carry the same error_code and no
//   payload until the in_last beat, which then restarts the decoder.
// Reset (rst, synchronous) empties both registers, the list stack and all
//   parse state. A stalled output holds its beat; the input register keeps
//   taking beats until it is full, then in_stall rises in the same cycle.
module rlp_stream_decoder_core #(
  parameter int MAX_DEPTH = rlpd_pkg::DEF_MAX_DEPTH,
  parameter int LEN_BITS  = rlpd_pkg::DEF_LEN_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] item_kind,
  output logic [2:0] error_code,
  output logic       stream_end
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // decode step fires when the input register holds a beat and the output register is free or draining
  logic adv;

  rlpd_pkg::stk_ctl_t  stk_ctl;
  rlpd_pkg::stk_stat_t stk_stat;
  logic [LEN_BITS-1:0] push_end;
  logic [LEN_BITS-1:0] top_end;
  logic [7:0]          res_byte;
  logic [1:0]          res_kind;
  logic [2:0]          res_err;

  assign adv      = in_vld_q && (!out_valid || !out_stall);
  assign in_stall = in_vld_q && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_q <= in_byte;
      in_last_q <= in_last;
    end
  end

  rlpd_parse #(
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_byte  (in_byte_q),
    .in_last  (in_last_q),
    .stat     (stk_stat),
    .top_end  (top_end),
    .ctl      (stk_ctl),
    .push_end (push_end),
    .res_byte (res_byte),
    .res_kind (res_kind),
    .res_err  (res_err)
  );

  rlpd_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctl      (stk_ctl),
    .push_end (push_end),
    .stat     (stk_stat),
    .top_end  (top_end)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte   <= res_byte;
      item_kind  <= res_kind;
      error_code <= res_err;
      stream_end <= in_last_q;
    end
  end

  // an error beat never carries payload
  a_err_no_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != rlpd_pkg::ERR_OK) |->
      (item_kind == rlpd_pkg::KIND_NONE) && (out_byte == 8'd0))
    else $error("error beat carries payload");

  // input side only backs up behind a held output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_vld_q && out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // every decode step lands in the output register
  a_step_lands: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("decoded beat lost");

  // the stack never pushes and pops, or clears and pushes, in the same step
  a_stack_excl: assert property (@(posedge clk) disable iff (rst)
    !(stk_ctl.push && stk_ctl.pop) && !(stk_ctl.clear && stk_ctl.push))
    else $error("conflicting stack commands");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import rlpd_pkg::*;

  // ---------------------------------------------------------------------------
  // Types and constants
  // ---------------------------------------------------------------------------
  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] ob;
    logic [1:0] kind;
    logic [2:0] err;
    logic       fin;
  } out_beat_t;

  typedef enum logic [1:0] {PH_PREFIX, PH_LENGTH, PH_PAYLOAD} dec_phase_t;

  localparam logic [63:0] POS_MASK = (64'd1 << DEF_LEN_BITS) - 64'd1;
  localparam int RANDOM_BEATS = 1100;
  localparam int STALL_LIMIT  = 2000;   // watchdog: cycles with no beat moving
  localparam int HOLD_CYCLES  = 80;     // long receiver hold-off to back up the pipe

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] item_kind;
  logic [2:0] error_code;
  logic       stream_end;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rlp_stream_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .item_kind (item_kind),
    .error_code(error_code),
    .stream_end(stream_end)
  );

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  in_beat_t  pend_beats[$];     // stimulus waiting for the driver
  out_beat_t want_beats[$];     // predicted results, oldest first
  int        total_beats = 0;
  int        beats_in = 0;      // accepted on the input channel
  int        beats_out = 0;     // accepted on the output channel
  int        errs = 0;
  int        quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Decoder predictor: own copy of the parse state
  // ---------------------------------------------------------------------------
  dec_phase_t  dec_phase;
  int unsigned lenb_left;
  logic [63:0] len_acc;
  logic        hdr_is_list;
  logic        single_chk;     // 0x81 prefix: payload byte must be >= 0x80
  logic [63:0] str_left;
  logic [63:0] stream_pos;
  logic [63:0] list_ends[DEF_MAX_DEPTH];
  int          open_lists;
  logic [2:0]  sticky_err;

  function automatic void clear_decoder();
    dec_phase   = PH_PREFIX;
    lenb_left   = 0;
    len_acc     = '0;
    hdr_is_list = 1'b0;
    single_chk  = 1'b0;
    str_left    = '0;
    stream_pos  = '0;
    open_lists  = 0;
    sticky_err  = ERR_OK;
  endfunction

  // end position of n bytes starting at nxt, checked against width and the
  // innermost open list
  function automatic logic [2:0] span_check(input logic [63:0] nxt, input logic [63:0] n,
                                            output logic [63:0] stop_pos);
    stop_pos = nxt + n;
    if (n > POS_MASK - nxt) return ERR_TOO_WIDE;
    if (open_lists > 0 && stop_pos > list_ends[open_lists-1]) return ERR_OVERRUN;
    return ERR_OK;
  endfunction

  function automatic logic [2:0] open_list(input logic [63:0] stop_pos);
    if (open_lists >= DEF_MAX_DEPTH) return ERR_TOO_DEEP;
    list_ends[open_lists] = stop_pos;
    open_lists++;
    return ERR_OK;
  endfunction

  // an item finished just before nxt: pop every list that ends there too
  function automatic void close_lists(input logic [63:0] nxt);
    while (open_lists > 0 && list_ends[open_lists-1] == nxt) open_lists--;
  endfunction

  function automatic logic [2:0] consume(input logic [7:0] b, input logic [63:0] nxt,
                                         output logic [1:0] kind, output logic [7:0] ob);
    logic [63:0] stop_pos;
    logic [2:0]  e;
    int unsigned nb;
    kind = KIND_NONE;
    ob   = 8'h00;
    stop_pos = '0;

    if (dec_phase == PH_LENGTH) begin
      if (len_acc == 0 && b == 8'h00) return ERR_LEAD_ZERO;
      if (len_acc > (POS_MASK >> 8)) return ERR_TOO_WIDE;
      len_acc = (len_acc << 8) | 64'(b);
      if (lenb_left > 0) lenb_left--;
      if (lenb_left != 0) return ERR_OK;
      if (len_acc < LONG_MIN) return ERR_SHORT_LF;
      e = span_check(nxt, len_acc, stop_pos);
      if (e != ERR_OK) return e;
      if (hdr_is_list) begin
        e = open_list(stop_pos);
        if (e != ERR_OK) return e;
        dec_phase = PH_PREFIX;
      end else begin
        str_left   = len_acc;
        single_chk = 1'b0;
        dec_phase  = PH_PAYLOAD;
      end
      return ERR_OK;
    end

    if (dec_phase == PH_PAYLOAD) begin
      if (single_chk && b <= B_SINGLE_MAX) return ERR_NONCANON;
      single_chk = 1'b0;
      ob = b;
      if (str_left > 0) str_left--;
      if (str_left == 0) begin
        kind      = KIND_LAST;
        dec_phase = PH_PREFIX;
        close_lists(nxt);
      end else begin
        kind = KIND_BYTE;
      end
      return ERR_OK;
    end

    // prefix byte
    dec_phase = PH_PREFIX;
    if (b <= B_SINGLE_MAX) begin
      ob   = b;
      kind = KIND_LAST;
      close_lists(nxt);
    end else if (b == B_STR_EMPTY) begin
      kind = KIND_EMPTY;
      close_lists(nxt);
    end else if (b <= B_STR_SHORT) begin
      e = span_check(nxt, 64'(b) - 64'(B_STR_EMPTY), stop_pos);
      if (e != ERR_OK) return e;
      str_left   = 64'(b) - 64'(B_STR_EMPTY);
      single_chk = (b == B_STR_ONE);
      dec_phase  = PH_PAYLOAD;
    end else if (b <= B_STR_LONG || b > B_LIST_SHORT) begin
      nb = (b <= B_STR_LONG) ? int'(b - B_STR_SHORT) : int'(b - B_LIST_SHORT);
      e = span_check(nxt, 64'(nb), stop_pos);
      if (e != ERR_OK) return e;
      lenb_left   = nb;
      len_acc     = '0;
      hdr_is_list = (b > B_LIST_SHORT);
      dec_phase   = PH_LENGTH;
    end else if (b == B_LIST_EMPTY) begin
      close_lists(nxt);
    end else begin
      e = span_check(nxt, 64'(b) - 64'(B_LIST_EMPTY), stop_pos);
      if (e != ERR_OK) return e;
      return open_list(stop_pos);
    end
    return ERR_OK;
  endfunction

  // expected result of one accepted input beat
  function automatic out_beat_t decode_beat(input logic [7:0] b, input logic fin);
    out_beat_t   r;
    logic [63:0] nxt;
    nxt    = (stream_pos + 64'd1) & POS_MASK;
    r.kind = KIND_NONE;
    r.ob   = 8'h00;
    r.err  = sticky_err;
    r.fin  = fin;
    if (r.err == ERR_OK) r.err = consume(b, nxt, r.kind, r.ob);
    stream_pos = nxt;
    if (r.err == ERR_OK && fin && (dec_phase != PH_PREFIX || open_lists != 0))
      r.err = ERR_TRUNC;
    if (r.err != ERR_OK) begin
      sticky_err = r.err;
      r.kind     = KIND_NONE;
      r.ob       = 8'h00;
    end
    if (fin) clear_decoder();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------------
  // length header: short form below 56, else minimal big-endian length field
  function automatic octets_t enc_hdr(input int unsigned n, input logic [7:0] base);
    octets_t     h;
    int unsigned v;
    if (n < LONG_MIN) begin
      h = {h, base + 8'(n)};
      return h;
    end
    v = n;
    while (v != 0) begin
      h.push_front(8'(v));
      v = v >> 8;
    end
    h.push_front(base + 8'(LONG_MIN - 1) + 8'(h.size()));
    return h;
  endfunction

  function automatic octets_t rand_string();
    octets_t     q;
    int unsigned len, r;
    logic [7:0]  v;
    r = $urandom_range(99);
    if (r < 30) begin
      v = 8'($urandom_range(255));
      if (v > B_SINGLE_MAX) q = {q, B_STR_ONE};
      q = {q, v};
      return q;
    end
    if (r < 65)      len = $urandom_range(20);
    else if (r < 85) len = $urandom_range(55, 21);
    else if (r < 98) len = $urandom_range(75, 56);
    else             len = $urandom_range(300, 256);   // two-byte length field
    q = enc_hdr(len, B_STR_EMPTY);
    repeat (len) q = {q, 8'($urandom)};
    return q;
  endfunction

  function automatic octets_t rand_item(input int depth);
    octets_t body, q;
    int      n;
    if (depth < 4 && $urandom_range(99) < 30) begin
      n = $urandom_range(4);
      repeat (n) body = {body, rand_item(depth + 1)};
      q = enc_hdr(body.size(), B_LIST_EMPTY);
      q = {q, body};
      return q;
    end
    return rand_string();
  endfunction

  // k lists wrapped around one string; k above the stack depth must trip
  function automatic octets_t nest_lists(input int k);
    octets_t q;
    q = rand_string();
    repeat (k) q = {enc_hdr(q.size(), B_LIST_EMPTY), q};
    return q;
  endfunction

  function automatic void add_stream(input octets_t q);
    in_beat_t s;
    foreach (q[i]) begin
      s.b   = q[i];
      s.fin = (i == q.size() - 1);
      pend_beats = {pend_beats, s};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: one beat per acceptance, random sender gaps by phase
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    in_beat_t nb;
    int       gap_pct;
    if (rst) begin
      in_valid <= 1'b0;
      in_byte  <= 8'h00;
      in_last  <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        want_beats = {want_beats, decode_beat(in_byte, in_last)};
        beats_in++;
      end
      // sender gaps: 28% first third, 70% second third, none after
      if (beats_in * 3 < total_beats)          gap_pct = 28;
      else if (beats_in * 3 < total_beats * 2) gap_pct = 70;
      else                                     gap_pct = 0;
      if (pend_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nb = pend_beats.pop_front();
        in_valid <= 1'b1;
        in_byte  <= nb.b;
        in_last  <= nb.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and receiver stall
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : watch_out
    out_beat_t want;
    int        stall_pct;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_out++;
        if (want_beats.size() == 0) begin
          $error("result beat with nothing expected: byte %0h kind %0d err %0d",
                 out_byte, item_kind, error_code);
          errs++;
        end else begin
          want = want_beats.pop_front();
          if (out_byte !== want.ob) begin
            $error("out_byte expected %0h got %0h", want.ob, out_byte);
            errs++;
          end
          if (item_kind !== want.kind) begin
            $error("item_kind expected %0d got %0d", want.kind, item_kind);
            errs++;
          end
          if (error_code !== want.err) begin
            $error("error_code expected %0d got %0d", want.err, error_code);
            errs++;
          end
          if (stream_end !== want.fin) begin
            $error("stream_end expected %0d got %0d", want.fin, stream_end);
            errs++;
          end
        end
      end
      // receiver stalls: 70% first third, 28% second, none in the last,
      // where one long hold-off makes the decoder back up into in_stall
      if (beats_out * 3 < total_beats)          stall_pct = 70;
      else if (beats_out * 3 < total_beats * 2) stall_pct = 28;
      else                                      stall_pct = 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && beats_out * 6 >= total_beats * 5) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any beat moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stim
    octets_t s;
    int      r, n, cut;
    clear_decoder();

    // directed: byte extremes, empty string and list, one-byte string
    add_stream('{8'h00, 8'h7f, 8'h80, 8'hc0, 8'h81, 8'hff});
    add_stream('{8'h81, 8'h05});                    // single byte not canonical
    add_stream('{8'hb8, 8'h00});                    // leading zero in length
    add_stream('{8'hb8, 8'h10});                    // long form below 56
    add_stream('{8'hc1, 8'h82, 8'haa});             // string overruns its list
    add_stream('{8'hbb, 8'hff, 8'hff, 8'hff, 8'hff}); // end past position range
    add_stream('{8'h83, 8'h01});                    // stream ends inside a string

    // nesting at and just beyond the stack depth
    add_stream(nest_lists(DEF_MAX_DEPTH));
    add_stream(nest_lists(DEF_MAX_DEPTH + 1));

    // random streams: mostly well formed, some corrupted, some noise
    while (pend_beats.size() < RANDOM_BEATS) begin
      s = {};
      r = $urandom_range(99);
      if (r < 6) begin
        s = nest_lists($urandom_range(DEF_MAX_DEPTH + 2, DEF_MAX_DEPTH - 2));
      end else if (r < 90) begin
        n = $urandom_range(3, 1);
        repeat (n) s = {s, rand_item(0)};
        if (r >= 76) begin
          if (s.size() > 1 && $urandom_range(1)) begin
            cut = $urandom_range(s.size() - 1, 1);
            s = s[0:cut-1];
          end else begin
            s[$urandom_range(s.size() - 1)] = 8'($urandom);
          end
        end
      end else begin
        n = $urandom_range(12, 1);
        repeat (n) s = {s, 8'($urandom)};
      end
      add_stream(s);
    end
    total_beats = pend_beats.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (beats_in != total_beats || want_beats.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);   // catch any stray trailing beat

    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rlpd_pkg.sv
hw/rtl/rlpd_stack.sv
hw/rtl/rlpd_parse.sv
hw/rtl/rlp_stream_decoder_core.sv
tb/tb_top.sv
